// ----- hw/rtl/box_fold_4d_tiled_assert.svh -----
// Assertion macros for the tiled 4D box fold.
// In synthesis builds the macros expand to nothing.
`ifndef BOX_FOLD_4D_TILED_ASSERT_SVH
`define BOX_FOLD_4D_TILED_ASSERT_SVH
`ifndef SYNTHESIS
`define BFT_ASSERT_NOW(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("box fold assertion failed");
`define BFT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("box fold assertion failed");
`else
`define BFT_ASSERT_NOW(lbl, clk, rst_n, prop)
`define BFT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- hw/rtl/bft_pkg.sv -----
`timescale 1ns / 1ps
package bft_pkg;

  localparam int WORD_BITS  = 32;
  localparam int FRAC_BITS  = 16;
  localparam int CFG_W      = 31;
  localparam int CTRL_W     = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int NUM_AXES   = 4;
  localparam int REM_STAGES = WORD_BITS;
  // Input register, one stage per quotient bit, reduce stage, fold stage.
  localparam int PIPE_LAT   = REM_STAGES + 3;
  localparam int CTRL_LIMITED_BIT = 4;

  localparam logic signed [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  localparam logic [CFG_W-1:0]  RST_SIZE  = CFG_W'(131072);
  localparam logic [CFG_W-1:0]  RST_SCALE = CFG_W'(65536);
  localparam logic [CTRL_W-1:0] RST_CTRL  = CTRL_W'(1);
  localparam logic [CFG_W-1:0]  RST_REP   = CFG_W'(65536);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE_X     = 3'd0,
    REG_SIZE_Y     = 3'd1,
    REG_SIZE_Z     = 3'd2,
    REG_SIZE_W     = 3'd3,
    REG_TILE_SCALE = 3'd4,
    REG_FOLD_CTRL  = 3'd5,
    REG_REPEAT_POS = 3'd6,
    REG_REPEAT_NEG = 3'd7
  } cfg_reg_t;

  // Per-axis constants derived from the configuration registers.
  typedef struct packed {
    logic [CFG_W-1:0]            m;
    logic                        m_pos;
    logic [CFG_W-1:0]            s;
    logic                        s_zero;
    logic [CFG_W-1:0]            s2;
    logic signed [WORD_BITS-1:0] upper;
    logic signed [WORD_BITS-1:0] lower;
  } bft_axis_t;

  function automatic logic signed [WORD_BITS-1:0] sat_word(
      input logic signed [WORD_BITS+1:0] v);
    logic signed [WORD_BITS-1:0] r;
    if (v > (WORD_BITS+2)'(WORD_MAX)) begin
      r = WORD_MAX;
    end else if (v < (WORD_BITS+2)'(WORD_MIN)) begin
      r = WORD_MIN;
    end else begin
      r = v[WORD_BITS-1:0];
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/box_fold_4d_tiled.sv -----
`timescale 1ns / 1ps
// Tiled 4D box fold, signed Q16.16.
// out_valid marks the cycle in which the folded result is shown.
// Throughput: one transaction per cycle; busy stays low, start is always taken.
// Reset (rst_n low, synchronous) loads the register defaults and empties the pipeline.
// The receiver cannot stall: each result is shown for exactly one cycle.
`include "box_fold_4d_tiled_assert.svh"
module box_fold_4d_tiled (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [bft_pkg::WORD_BITS-1:0] in_point_x,
  input  logic signed [bft_pkg::WORD_BITS-1:0] in_point_y,
  input  logic signed [bft_pkg::WORD_BITS-1:0] in_point_z,
  input  logic signed [bft_pkg::WORD_BITS-1:0] in_point_w,
  output logic                                out_valid,
  output logic signed [bft_pkg::WORD_BITS-1:0] out_folded_x,
  output logic signed [bft_pkg::WORD_BITS-1:0] out_folded_y,
  output logic signed [bft_pkg::WORD_BITS-1:0] out_folded_z,
  output logic signed [bft_pkg::WORD_BITS-1:0] out_folded_w,
  input  logic                                cfg_we,
  input  logic [bft_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bft_pkg::CFG_W-1:0]           cfg_data
);
  import bft_pkg::*;

  // The pipeline has no stall: every stage advances each cycle, and a
  // valid bit travels beside each transaction. The rate is set by the
  // bit-per-stage remainder pipeline, which takes a new point every cycle.

  // Configuration registers.
  logic [CFG_W-1:0]  size_r [NUM_AXES];
  logic [CFG_W-1:0]  scale_r, rpos_r, rneg_r;
  logic [CTRL_W-1:0] ctrl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        size_r[i] <= RST_SIZE;
      end
      scale_r <= RST_SCALE;
      ctrl_r  <= RST_CTRL;
      rpos_r  <= RST_REP;
      rneg_r  <= RST_REP;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SIZE_X:     size_r[0] <= cfg_data;
        REG_SIZE_Y:     size_r[1] <= cfg_data;
        REG_SIZE_Z:     size_r[2] <= cfg_data;
        REG_SIZE_W:     size_r[3] <= cfg_data;
        REG_TILE_SCALE: scale_r   <= cfg_data;
        REG_FOLD_CTRL:  ctrl_r    <= cfg_data[CTRL_W-1:0];
        REG_REPEAT_POS: rpos_r    <= cfg_data;
        REG_REPEAT_NEG: rneg_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register and valid chain. The derived period m is registered
  // from the configuration registers in bft_cfg_derive; the window bounds
  // settle long before the fold stages.
  logic                        vld_r [PIPE_LAT];
  logic signed [WORD_BITS-1:0] pt_r  [NUM_AXES];
  logic                        accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PIPE_LAT; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else begin
      vld_r[0] <= accept;
      for (int i = 1; i < PIPE_LAT; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    pt_r[0] <= in_point_x;
    pt_r[1] <= in_point_y;
    pt_r[2] <= in_point_z;
    pt_r[3] <= in_point_w;
  end

  // One lane per axis: derived constants, remainder pipeline, fold stages.
  bft_axis_t                   axis_w [NUM_AXES];
  logic signed [WORD_BITS-1:0] c_w    [NUM_AXES];
  logic [WORD_BITS-1:0]        rem_w  [NUM_AXES];
  logic signed [WORD_BITS-1:0] fold_w [NUM_AXES];

  for (genvar k = 0; k < NUM_AXES; k++) begin : g_axis
    bft_cfg_derive u_derive (
      .clk     (clk),
      .size    (size_r[k]),
      .scale   (scale_r),
      .rep_pos (rpos_r),
      .rep_neg (rneg_r),
      .axis    (axis_w[k])
    );

    bft_rem_pipe u_rem (
      .clk     (clk),
      .in_c    (pt_r[k]),
      .m       (axis_w[k].m),
      .out_c   (c_w[k]),
      .out_rem (rem_w[k])
    );

    bft_fold_out u_fold (
      .clk     (clk),
      .c       (c_w[k]),
      .rem     (rem_w[k]),
      .axis    (axis_w[k]),
      .en      (ctrl_r[k]),
      .limited (ctrl_r[CTRL_LIMITED_BIT]),
      .folded  (fold_w[k])
    );
  end

  assign out_valid    = vld_r[PIPE_LAT-1];
  assign out_folded_x = fold_w[0];
  assign out_folded_y = fold_w[1];
  assign out_folded_z = fold_w[2];
  assign out_folded_w = fold_w[3];

  // The remainder leaving the pipeline must be below the period.
  `BFT_ASSERT_NOW(a_rem_below_period, clk, rst_n, !(vld_r[REM_STAGES] && axis_w[0].m_pos) || (rem_w[0] < WORD_BITS'(axis_w[0].m)))
  // An accepted transaction enters the valid chain on the next cycle.
  `BFT_ASSERT_NEXT(a_accept_enters, clk, rst_n, accept, vld_r[0])

endmodule

// ----- hw/rtl/bft_cfg_derive.sv -----
`timescale 1ns / 1ps
module bft_cfg_derive (
  input  logic                     clk,
  input  logic [bft_pkg::CFG_W-1:0] size,
  input  logic [bft_pkg::CFG_W-1:0] scale,
  input  logic [bft_pkg::CFG_W-1:0] rep_pos,
  input  logic [bft_pkg::CFG_W-1:0] rep_neg,
  output bft_pkg::bft_axis_t        axis
);
  import bft_pkg::*;

  localparam int P1_W = 2 * CFG_W;
  localparam int P2_W = 2 * CFG_W + 1;

  logic [P1_W-1:0]    prod_m;
  logic [CFG_W-1:0]   m_r, m_nxt, m_d2_r;
  logic               mpos_r;
  logic [CFG_W-1:0]   s_r, s_d2_r, s_d3_r;
  logic [CFG_W:0]     rp1_r, rn1_r;
  logic [P2_W-1:0]    prod_hp, prod_hn;
  logic [CFG_W-1:0]   hp_r, hp_nxt, hn_r, hn_nxt;
  logic signed [WORD_BITS-1:0] upper_r, lower_r;
  logic [CFG_W-1:0]   s2_r;
  logic               szero_r;

  // Stage one: period m = size * scale, fraction dropped, saturated.
  assign prod_m = P1_W'(size) * P1_W'(scale);
  assign m_nxt  = (|prod_m[P1_W-1:FRAC_BITS+CFG_W]) ? {CFG_W{1'b1}}
                                                    : prod_m[FRAC_BITS+CFG_W-1:FRAC_BITS];

  // Stage two: half windows (repeat + 1) * m / 2, saturated.
  assign prod_hp = P2_W'(rp1_r) * P2_W'(m_d2_r);
  assign prod_hn = P2_W'(rn1_r) * P2_W'(m_d2_r);
  assign hp_nxt  = (|prod_hp[P2_W-1:FRAC_BITS+1+CFG_W]) ? {CFG_W{1'b1}}
                                                        : prod_hp[FRAC_BITS+CFG_W:FRAC_BITS+1];
  assign hn_nxt  = (|prod_hn[P2_W-1:FRAC_BITS+1+CFG_W]) ? {CFG_W{1'b1}}
                                                        : prod_hn[FRAC_BITS+CFG_W:FRAC_BITS+1];

  always_ff @(posedge clk) begin
    m_r     <= m_nxt;
    mpos_r  <= |m_nxt;
    s_r     <= size;
    rp1_r   <= (CFG_W+1)'(rep_pos) + (CFG_W+1)'(1 << FRAC_BITS);
    rn1_r   <= (CFG_W+1)'(rep_neg) + (CFG_W+1)'(1 << FRAC_BITS);
    m_d2_r  <= m_r;
    s_d2_r  <= s_r;
    hp_r    <= hp_nxt;
    hn_r    <= hn_nxt;
    s_d3_r  <= s_d2_r;
    upper_r <= $signed({1'b0, hp_r}) - $signed({1'b0, s_d2_r});
    lower_r <= $signed({1'b0, s_d2_r}) - $signed({1'b0, hn_r});
    s2_r    <= s_d2_r[CFG_W-1] ? {CFG_W{1'b1}} : {s_d2_r[CFG_W-2:0], 1'b0};
    szero_r <= ~(|s_d2_r);
  end

  assign axis.m      = m_r;
  assign axis.m_pos  = mpos_r;
  assign axis.s      = s_d3_r;
  assign axis.s_zero = szero_r;
  assign axis.s2     = s2_r;
  assign axis.upper  = upper_r;
  assign axis.lower  = lower_r;

endmodule

// ----- hw/rtl/bft_rem_pipe.sv -----
`timescale 1ns / 1ps
module bft_rem_pipe (
  input  logic                                clk,
  input  logic signed [bft_pkg::WORD_BITS-1:0] in_c,
  input  logic [bft_pkg::CFG_W-1:0]           m,
  output logic signed [bft_pkg::WORD_BITS-1:0] out_c,
  output logic [bft_pkg::WORD_BITS-1:0]       out_rem
);
  import bft_pkg::*;

  logic signed [WORD_BITS-1:0] c_r   [REM_STAGES];
  logic [WORD_BITS-1:0]        dvd_r [REM_STAGES];
  logic [WORD_BITS-1:0]        rem_r [REM_STAGES];
  logic [WORD_BITS-1:0]        mag;

  // Magnitude of the coordinate; the most negative value maps to 2^31.
  assign mag = in_c[WORD_BITS-1] ? (WORD_BITS'(0) - in_c) : in_c;

  // Restoring remainder, one dividend bit per stage.
  for (genvar k = 0; k < REM_STAGES; k++) begin : g_stage
    logic [WORD_BITS-1:0] rem_prev, dvd_prev;
    logic [WORD_BITS:0]   trial;
    logic signed [WORD_BITS-1:0] c_prev;

    if (k == 0) begin : g_first
      assign rem_prev = '0;
      assign dvd_prev = mag;
      assign c_prev   = in_c;
    end else begin : g_next
      assign rem_prev = rem_r[k-1];
      assign dvd_prev = dvd_r[k-1];
      assign c_prev   = c_r[k-1];
    end

    assign trial = {rem_prev, dvd_prev[WORD_BITS-1]};

    always_ff @(posedge clk) begin
      c_r[k]   <= c_prev;
      dvd_r[k] <= {dvd_prev[WORD_BITS-2:0], 1'b0};
      if (trial >= (WORD_BITS+1)'(m)) begin
        rem_r[k] <= WORD_BITS'(trial - (WORD_BITS+1)'(m));
      end else begin
        rem_r[k] <= trial[WORD_BITS-1:0];
      end
    end
  end

  assign out_c   = c_r[REM_STAGES-1];
  assign out_rem = rem_r[REM_STAGES-1];

endmodule

// ----- hw/rtl/bft_fold_out.sv -----
`timescale 1ns / 1ps
module bft_fold_out (
  input  logic                                clk,
  input  logic signed [bft_pkg::WORD_BITS-1:0] c,
  input  logic [bft_pkg::WORD_BITS-1:0]       rem,
  input  bft_pkg::bft_axis_t                  axis,
  input  logic                                en,
  input  logic                                limited,
  output logic signed [bft_pkg::WORD_BITS-1:0] folded
);
  import bft_pkg::*;

  logic [WORD_BITS-1:0]        m_minus;
  logic signed [WORD_BITS:0]   red;
  logic signed [WORD_BITS:0]   red_signed;
  logic                        in_win, pass_nxt;
  logic signed [WORD_BITS-1:0] c_a_r, cred_a_r, cred_nxt;
  logic                        pass_a_r;
  logic signed [WORD_BITS-1:0] negc, s_w, s2_w;
  logic signed [WORD_BITS+1:0] sum_hi, sum_lo;
  logic signed [WORD_BITS-1:0] folded_r, folded_nxt;

  // Reduce stage: remainder to a value nearest zero; a tie takes the sign opposite to the coordinate.
  always_comb begin
    m_minus    = WORD_BITS'(axis.m) - rem;
    if (rem >= m_minus) begin
      red = $signed({1'b0, rem}) - $signed((WORD_BITS+1)'(axis.m));
    end else begin
      red = $signed({1'b0, rem});
    end
    red_signed = c[WORD_BITS-1] ? -red : red;
    cred_nxt   = axis.m_pos ? red_signed[WORD_BITS-1:0] : c;
    in_win     = (c < axis.upper) && (c > axis.lower);
    pass_nxt   = !en || axis.s_zero || (limited && !in_win);
  end

  always_ff @(posedge clk) begin
    c_a_r    <= c;
    cred_a_r <= cred_nxt;
    pass_a_r <= pass_nxt;
  end

  // Fold stage: reflect about +s or -s, or pass the coordinate through.
  always_comb begin
    s_w    = $signed({1'b0, axis.s});
    s2_w   = $signed({1'b0, axis.s2});
    negc   = (cred_a_r == WORD_MIN) ? WORD_MAX : -cred_a_r;
    sum_hi = (WORD_BITS+2)'(s2_w) + (WORD_BITS+2)'(negc);
    sum_lo = -((WORD_BITS+2)'(s2_w)) + (WORD_BITS+2)'(negc);
    if (pass_a_r) begin
      folded_nxt = c_a_r;
    end else if (cred_a_r > s_w) begin
      folded_nxt = sat_word(sum_hi);
    end else if (cred_a_r < -s_w) begin
      folded_nxt = sat_word(sum_lo);
    end else begin
      folded_nxt = cred_a_r;
    end
  end

  always_ff @(posedge clk) begin
    folded_r <= folded_nxt;
  end

  assign folded = folded_r;

endmodule
